[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every clock edge outside reset.
`define SRE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// When ante holds, cons must hold in the following clock cycle.
`define SRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/sre_pkg.sv]
// Shared types and constants of the spline refinement error block.
package sre_pkg;

	localparam logic [1:0] REQ_KNOT   = 2'd0;
	localparam logic [1:0] REQ_COEF   = 2'd1;
	localparam logic [1:0] REQ_ENTRY  = 2'd2;
	localparam logic [1:0] REQ_FINISH = 2'd3;

	localparam logic [2:0] CFG_ORDER = 3'd0;
	localparam logic [2:0] CFG_DIM   = 3'd1;
	localparam logic [2:0] CFG_COUNT = 3'd2;
	localparam logic [2:0] CFG_LEFT  = 3'd3;
	localparam logic [2:0] CFG_RIGHT = 3'd4;

	localparam int DIV_NW = 77;
	localparam int DIV_DW = 32;
	localparam int SQ_IW  = 64;
	localparam int SQ_OW  = 32;

	typedef struct packed {
		logic [3:0]  order;
		logic [1:0]  dimension;
		logic [10:0] coef_count;
		logic [3:0]  left_fixed;
		logic [3:0]  right_fixed;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [10:0]        index;
		logic signed [31:0] val_x;
		logic signed [31:0] val_y;
		logic signed [31:0] val_z;
		logic [16:0]        weight;
		logic [30:0]        row_span;
		logic               last_in_row;
		logic               ok;
		logic               scaled;
	} item_t;

endpackage

[rtl/spline_refinement_error_norms.sv]
// Top level of the spline refinement error norm block.
//
// Knots, then coefficients, then refinement-matrix entries are issued with
// start while busy is low; a finish request reports the per-component
// maximum and weighted L2 errors, which appear on the result ports for
// exactly one cycle with done high and must be taken then: the receiver
// cannot stall. A two-entry queue parts the front end from the back end,
// so busy rises only when two requests are waiting. The back-end
// sequencer writes a knot straight from dispatch; an unscaled coefficient
// goes to the store write; a scaled coefficient runs the serial divider,
// the square root and a scale multiply and saturate step per lane; a
// matrix entry does its lane multiply-accumulates in parallel, and the
// entry that closes a row adds per lane a squared error through the
// shared divider; a finish takes a square root per lane. The stores have
// no reset; the user writes configuration through cfg_valid/cfg_ready
// (always ready) only while the block is idle; the block does not check it.
module spline_refinement_error_norms #(
	parameter int MAX_COEFS  = 1024,
	parameter int MAX_ORDER  = 8,
	parameter int MAX_DIM    = 3,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [10:0]        index,
	input  logic signed [31:0] val_x,
	input  logic signed [31:0] val_y,
	input  logic signed [31:0] val_z,
	input  logic [16:0]        weight,
	input  logic [30:0]        row_span,
	input  logic               last_in_row,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	output logic               done,
	output logic [30:0]        max_err_x,
	output logic [30:0]        max_err_y,
	output logic [30:0]        max_err_z,
	output logic [30:0]        l2_err_x,
	output logic [30:0]        l2_err_y,
	output logic [30:0]        l2_err_z
);
	sre_pkg::cfg_t  cfg_q;
	sre_pkg::item_t head;
	logic           head_valid;
	logic           pop;

	assign cfg_ready = 1'b1;

	// Register file: each transfer updates one register, others are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order       <= 4'd4;
			cfg_q.dimension   <= 2'd3;
			cfg_q.coef_count  <= 11'd1024;
			cfg_q.left_fixed  <= 4'd0;
			cfg_q.right_fixed <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sre_pkg::CFG_ORDER: cfg_q.order       <= cfg_data[3:0];
				sre_pkg::CFG_DIM:   cfg_q.dimension   <= cfg_data[1:0];
				sre_pkg::CFG_COUNT: cfg_q.coef_count  <= cfg_data;
				sre_pkg::CFG_LEFT:  cfg_q.left_fixed  <= cfg_data[3:0];
				sre_pkg::CFG_RIGHT: cfg_q.right_fixed <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Classify and hold requests until the back end is free.
	sre_front #(
		.MAX_COEFS (MAX_COEFS),
		.MAX_ORDER (MAX_ORDER)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.index       (index),
		.val_x       (val_x),
		.val_y       (val_y),
		.val_z       (val_z),
		.weight      (weight),
		.row_span    (row_span),
		.last_in_row (last_in_row),
		.cfg         (cfg_q),
		.pop         (pop),
		.busy        (busy),
		.head_valid  (head_valid),
		.head        (head)
	);

	// Advance one queued request at a time through stores and arithmetic.
	sre_back #(
		.MAX_COEFS  (MAX_COEFS),
		.MAX_ORDER  (MAX_ORDER),
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.cfg        (cfg_q),
		.pop        (pop),
		.done       (done),
		.max_err_x  (max_err_x),
		.max_err_y  (max_err_y),
		.max_err_z  (max_err_z),
		.l2_err_x   (l2_err_x),
		.l2_err_y   (l2_err_y),
		.l2_err_z   (l2_err_z)
	);
endmodule

[rtl/sre_div.sv]
// Restoring divider, one quotient bit per cycle.
module sre_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [sre_pkg::DIV_NW-1:0]     dividend,
	input  logic [sre_pkg::DIV_DW-1:0]     divisor,
	output logic                           done,
	output logic [sre_pkg::DIV_NW-1:0]     quotient
);
	localparam int NW = sre_pkg::DIV_NW;
	localparam int DW = sre_pkg::DIV_DW;
	localparam int CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dv_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          ge;

	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, dv_q};
	assign rem_sub = rem_sh - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[rtl/sre_sqrt.sv]
// Integer square root, one result bit per cycle.
module sre_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [sre_pkg::SQ_IW-1:0]  radicand,
	output logic                       done,
	output logic [sre_pkg::SQ_OW-1:0]  root
);
	localparam int IW = sre_pkg::SQ_IW;
	localparam int OW = sre_pkg::SQ_OW;
	localparam int RW = OW + 2;
	localparam int CW = $clog2(OW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] x_q;
	logic [RW-1:0] rem_q;
	logic [OW-1:0] root_q;
	logic [RW+1:0] rem_n;
	logic [RW+1:0] trial;
	logic [RW+1:0] rem_sub;
	logic          ge;

	assign rem_n   = {rem_q, x_q[IW-1:IW-2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = rem_n >= trial;
	assign rem_sub = rem_n - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(OW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[IW-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RW-1:0] : rem_n[RW-1:0];
			root_q <= {root_q[OW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

[rtl/sre_front.sv]
// Front end: take items, classify them and queue them for the back end.
module sre_front #(
	parameter int MAX_COEFS = 1024,
	parameter int MAX_ORDER = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          req_type,
	input  logic [10:0]         index,
	input  logic signed [31:0]  val_x,
	input  logic signed [31:0]  val_y,
	input  logic signed [31:0]  val_z,
	input  logic [16:0]         weight,
	input  logic [30:0]         row_span,
	input  logic                last_in_row,
	input  sre_pkg::cfg_t       cfg,
	input  logic                pop,
	output logic                busy,
	output logic                head_valid,
	output sre_pkg::item_t      head
);
	localparam int KD = MAX_COEFS + MAX_ORDER;

	sre_pkg::item_t q_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           ok;
	logic           scaled;
	logic           coef_ok;

	assign push    = start && !busy;
	assign coef_ok = (index < cfg.coef_count) && (32'(index) < MAX_COEFS);
	assign scaled  = (index >= 11'(cfg.left_fixed)) &&
		((12'(index) + 12'(cfg.right_fixed)) < 12'(cfg.coef_count));

	always_comb begin
		case (req_type)
			sre_pkg::REQ_KNOT:   ok = 32'(index) < KD;
			sre_pkg::REQ_COEF:   ok = coef_ok;
			sre_pkg::REQ_ENTRY:  ok = coef_ok;
			sre_pkg::REQ_FINISH: ok = 1'b1;
			default:             ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= '{req_type: req_type, index: index, val_x: val_x, val_y: val_y,
				val_z: val_z, weight: weight, row_span: row_span,
				last_in_row: last_in_row, ok: ok, scaled: scaled};
		end
	end

	assign busy       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = q_q[rd_q];
endmodule

[rtl/sre_back.sv]
// Back end: stores, lane arithmetic and the sequencer that runs queued items.
module sre_back #(
	parameter int MAX_COEFS  = 1024,
	parameter int MAX_ORDER  = 8,
	parameter int MAX_DIM    = 3,
	parameter int VALUE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sre_pkg::item_t  head,
	input  sre_pkg::cfg_t   cfg,
	output logic            pop,
	output logic            done,
	output logic [30:0]     max_err_x,
	output logic [30:0]     max_err_y,
	output logic [30:0]     max_err_z,
	output logic [30:0]     l2_err_x,
	output logic [30:0]     l2_err_y,
	output logic [30:0]     l2_err_z
);
	localparam int CB  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam int KD  = MAX_COEFS + MAX_ORDER;
	localparam int KAW = $clog2(KD);
	localparam int CAW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int KW  = $clog2(MAX_ORDER + 1);
	localparam int LW  = $clog2(MAX_DIM + 1);
	localparam int LIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int FW  = 27;
	localparam int SPW = 32 + FW;
	localparam int PW  = CB + 17;
	localparam int AW  = (CB + 4 > 52) ? CB + 4 : 52;
	localparam logic [63:0] LIM = 64'd1 << (VALUE_BITS - 1);
	localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_K0    = 5'd2;
	localparam logic [4:0] S_K1    = 5'd3;
	localparam logic [4:0] S_DIV1  = 5'd4;
	localparam logic [4:0] S_SQ1   = 5'd5;
	localparam logic [4:0] S_SMUL  = 5'd6;
	localparam logic [4:0] S_SSAT  = 5'd7;
	localparam logic [4:0] S_SWR   = 5'd8;
	localparam logic [4:0] S_MAC   = 5'd9;
	localparam logic [4:0] S_ACC   = 5'd10;
	localparam logic [4:0] S_D     = 5'd11;
	localparam logic [4:0] S_W0    = 5'd12;
	localparam logic [4:0] S_W1    = 5'd13;
	localparam logic [4:0] S_W2    = 5'd14;
	localparam logic [4:0] S_W3    = 5'd15;
	localparam logic [4:0] S_W4    = 5'd16;
	localparam logic [4:0] S_FIN   = 5'd17;
	localparam logic [4:0] S_FWAIT = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	function automatic logic signed [31:0] lane_val(input sre_pkg::item_t it, input int j);
		case (j)
			0:       return it.val_x;
			1:       return it.val_y;
			2:       return it.val_z;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Saturate a magnitude with a sign to VALUE_BITS, held in CB bits.
	function automatic logic [CB-1:0] sat_val(input logic [63:0] m, input logic neg);
		logic [63:0] v;
		if (m >= LIM) v = neg ? (64'd0 - LIM) : (LIM - 64'd1);
		else          v = neg ? (64'd0 - m) : m;
		return CB'(v);
	endfunction

	logic [4:0]           state_q;
	logic [LW-1:0]        lane_q;
	sre_pkg::item_t       item_q;

	logic signed [31:0]   knot_mem [KD];
	logic signed [31:0]   knot_rd_q;
	logic signed [31:0]   kn0_q;
	logic [KAW-1:0]       knot_ra;
	logic                 knot_we;

	logic [MAX_DIM*CB-1:0] coef_mem [MAX_COEFS];
	logic [MAX_DIM*CB-1:0] coef_rd_q;
	logic [MAX_DIM*CB-1:0] coef_wd;
	logic                  coef_we;

	logic [FW-1:0]        f_q;
	logic [SPW-1:0]       smul_q;
	logic [CB-1:0]        scl_q   [MAX_DIM];
	logic [PW-1:0]        pm_q    [MAX_DIM];
	logic                 pneg_q  [MAX_DIM];
	logic signed [47:0]   row_q   [MAX_DIM];
	logic [30:0]          max_q   [MAX_DIM];
	logic [63:0]          sum_q   [MAX_DIM];
	logic [30:0]          d_q;
	logic [61:0]          d2_q;
	logic [61:0]          pl_q;
	logic [61:0]          ph_q;
	logic [30:0]          res_max_q [3];
	logic [30:0]          res_l2_q  [3];
	logic                 done_q;

	logic                       div_go_q;
	logic [sre_pkg::DIV_NW-1:0] div_a_q;
	logic [sre_pkg::DIV_DW-1:0] div_b_q;
	logic                       div_done;
	logic [sre_pkg::DIV_NW-1:0] div_quo;
	logic                       sq_go_q;
	logic [sre_pkg::SQ_IW-1:0]  sq_x_q;
	logic                       sq_done;
	logic [sre_pkg::SQ_OW-1:0]  sq_root;

	logic [KW-1:0]        k_eff;
	logic [LW-1:0]        lanes;
	logic [LW-1:0]        nout;
	logic [LW:0]          lane_nx;
	logic [LIW-1:0]       li;
	logic signed [32:0]   span;
	logic                 span_np;
	logic [31:0]          cur_m;
	logic                 cur_neg;
	logic [SPW-15:0]      srnd;
	logic signed [49:0]   dlt;
	logic [49:0]          dmag;
	logic [30:0]          dsat;
	logic [92:0]          wprod;
	logic [63:0]          wterm;
	logic [64:0]          wsum;
	logic [30:0]          l2_sat;

	always_comb begin
		if (cfg.order == 4'd0)             k_eff = KW'(1);
		else if (32'(cfg.order) > MAX_ORDER) k_eff = KW'(MAX_ORDER);
		else                               k_eff = KW'(cfg.order);
	end

	assign lanes   = (32'(cfg.dimension) < MAX_DIM) ? LW'(cfg.dimension) : LW'(MAX_DIM);
	assign nout    = (32'(lanes) < 3) ? lanes : LW'(3);
	assign lane_nx = {1'b0, lane_q} + 1'b1;
	assign li      = LIW'(lane_q);

	assign span    = {knot_rd_q[31], knot_rd_q} - {kn0_q[31], kn0_q};
	assign span_np = span[32] || (span == 33'sd0);
	assign cur_m   = mag32(lane_val(item_q, 32'(lane_q)));
	assign cur_neg = lane_val(item_q, 32'(lane_q)) < 0;
	assign srnd    = (SPW-14)'((smul_q + SPW'(32768)) >> 16);

	assign dlt  = $signed({{2{row_q[li][47]}}, row_q[li]}) -
		$signed({{18{lane_val(item_q, 32'(lane_q))[31]}}, lane_val(item_q, 32'(lane_q))});
	assign dmag = dlt[49] ? 50'(-dlt) : 50'(dlt);
	assign dsat = (dmag > 50'h7FFFFFFF) ? 31'h7FFFFFFF : dmag[30:0];

	assign wprod  = {ph_q, 31'b0} + {31'b0, pl_q};
	assign wterm  = (|div_quo[sre_pkg::DIV_NW-1:64]) ? {64{1'b1}} : div_quo[63:0];
	assign wsum   = {1'b0, sum_q[li]} + {1'b0, wterm};
	assign l2_sat = sq_root[31] ? 31'h7FFFFFFF : sq_root[30:0];

	assign pop     = (state_q == S_IDLE) && head_valid;
	assign knot_we = (state_q == S_DISP) && (item_q.req_type == sre_pkg::REQ_KNOT) && item_q.ok;
	assign knot_ra = (state_q == S_K0) ? (KAW'(item_q.index) + KAW'(k_eff))
		: KAW'(item_q.index);
	assign coef_we = state_q == S_SWR;

	always_comb begin
		for (int j = 0; j < MAX_DIM; j++) coef_wd[j*CB +: CB] = scl_q[j];
	end

	always_ff @(posedge clk) begin
		if (knot_we) knot_mem[KAW'(item_q.index)] <= item_q.val_x;
		knot_rd_q <= knot_mem[knot_ra];
	end

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[CAW'(item_q.index)] <= coef_wd;
		coef_rd_q <= coef_mem[CAW'(item_q.index)];
	end

	sre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	sre_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go_q),
		.radicand (sq_x_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Control and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lane_q   <= '0;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			for (int j = 0; j < MAX_DIM; j++) begin
				row_q[j] <= '0;
				max_q[j] <= '0;
				sum_q[j] <= '0;
			end
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					case (item_q.req_type)
						sre_pkg::REQ_COEF: begin
							if (!item_q.ok)          state_q <= S_IDLE;
							else if (!item_q.scaled) state_q <= S_SWR;
							else                     state_q <= S_K0;
						end
						sre_pkg::REQ_ENTRY: state_q <= S_MAC;
						sre_pkg::REQ_FINISH: begin
							lane_q  <= '0;
							state_q <= (nout == '0) ? S_OUT : S_FIN;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_K0: state_q <= S_K1;
				S_K1: begin
					if (span_np) state_q <= S_SWR;
					else begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						sq_go_q <= 1'b1;
						state_q <= S_SQ1;
					end
				end
				S_SQ1: begin
					if (sq_done) begin
						lane_q  <= '0;
						state_q <= S_SMUL;
					end
				end
				S_SMUL: state_q <= S_SSAT;
				S_SSAT: begin
					if (lane_q == LW'(MAX_DIM - 1)) state_q <= S_SWR;
					else begin
						lane_q  <= lane_nx[LW-1:0];
						state_q <= S_SMUL;
					end
				end
				S_SWR: state_q <= S_IDLE;
				S_MAC: state_q <= S_ACC;
				S_ACC: begin
					for (int j = 0; j < MAX_DIM; j++) begin
						logic [PW-1:0]     pr;
						logic signed [AW-1:0] a;
						pr = (pm_q[j] + PW'(32768)) >> 16;
						a  = $signed({{(AW-48){row_q[j][47]}}, row_q[j]});
						a  = pneg_q[j] ? a - $signed(AW'(pr)) : a + $signed(AW'(pr));
						if (32'(j) < 32'(lanes)) begin
							if (a > $signed(AW'(ACC_MAX)))      row_q[j] <= ACC_MAX;
							else if (a < AW'(ACC_MIN))          row_q[j] <= ACC_MIN;
							else                                row_q[j] <= 48'(a);
						end
					end
					if (item_q.last_in_row && lanes != '0) begin
						lane_q  <= '0;
						state_q <= S_D;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_D: begin
					if (dsat > max_q[li]) max_q[li] <= dsat;
					row_q[li] <= '0;
					state_q   <= S_W0;
				end
				S_W0: state_q <= S_W1;
				S_W1: state_q <= S_W2;
				S_W2: state_q <= S_W3;
				S_W3: begin
					div_go_q <= 1'b1;
					state_q  <= S_W4;
				end
				S_W4: begin
					if (div_done) begin
						sum_q[li] <= wsum[64] ? {64{1'b1}} : wsum[63:0];
						if (lane_nx < {1'b0, lanes}) begin
							lane_q  <= lane_nx[LW-1:0];
							state_q <= S_D;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FIN: begin
					sq_go_q <= 1'b1;
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					if (sq_done) begin
						if (lane_nx < {1'b0, nout}) begin
							lane_q  <= lane_nx[LW-1:0];
							state_q <= S_FIN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					done_q <= 1'b1;
					for (int j = 0; j < MAX_DIM; j++) begin
						row_q[j] <= '0;
						max_q[j] <= '0;
						sum_q[j] <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (head_valid) item_q <= head;
			end
			S_DISP: begin
				if (item_q.req_type == sre_pkg::REQ_COEF) begin
					for (int j = 0; j < MAX_DIM; j++)
						scl_q[j] <= CB'($signed(lane_val(item_q, j)));
				end
				if (item_q.req_type == sre_pkg::REQ_FINISH) begin
					for (int j = 0; j < 3; j++) begin
						res_max_q[j] <= '0;
						res_l2_q[j]  <= '0;
					end
				end
			end
			S_K0: kn0_q <= knot_rd_q;
			S_K1: begin
				for (int j = 0; j < MAX_DIM; j++) begin
					if (lane_val(item_q, j) == 32'sd0) scl_q[j] <= '0;
					else scl_q[j] <= sat_val({64{1'b1}}, lane_val(item_q, j) < 0);
				end
				div_a_q <= sre_pkg::DIV_NW'(k_eff) << 48;
				div_b_q <= span[31:0];
			end
			S_DIV1: begin
				if (div_done) sq_x_q <= div_quo[63:0];
			end
			S_SQ1: begin
				if (sq_done) f_q <= sq_root[FW-1:0];
			end
			S_SMUL: smul_q <= SPW'(cur_m) * SPW'(f_q);
			S_SSAT: scl_q[li] <= sat_val(64'(srnd), cur_neg);
			S_MAC: begin
				for (int j = 0; j < MAX_DIM; j++) begin
					logic signed [CB-1:0] c;
					logic [CB-1:0]        m;
					c = $signed(coef_rd_q[j*CB +: CB]);
					m = c[CB-1] ? CB'(-c) : CB'(c);
					if (!item_q.ok) m = '0;
					pm_q[j]   <= PW'(m) * PW'(item_q.weight);
					pneg_q[j] <= item_q.ok && c[CB-1];
				end
			end
			S_D:  d_q  <= dsat;
			S_W0: d2_q <= 62'(d_q) * 62'(d_q);
			S_W1: pl_q <= 62'(d2_q[30:0]) * 62'(item_q.row_span);
			S_W2: ph_q <= 62'(d2_q[61:31]) * 62'(item_q.row_span);
			S_W3: begin
				div_a_q <= wprod[92:16];
				div_b_q <= sre_pkg::DIV_DW'(k_eff);
			end
			S_FIN: sq_x_q <= sum_q[li];
			S_FWAIT: begin
				if (sq_done) begin
					res_max_q[2'(lane_q)] <= max_q[li];
					res_l2_q[2'(lane_q)]  <= l2_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign max_err_x = res_max_q[0];
	assign max_err_y = res_max_q[1];
	assign max_err_z = res_max_q[2];
	assign l2_err_x  = res_l2_q[0];
	assign l2_err_y  = res_l2_q[1];
	assign l2_err_z  = res_l2_q[2];
endmodule

[rtl/sre_checker.sv]
// Port-level checks of the spline refinement error block, bound to the top.
`include "assert_macros.svh"

module sre_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic done
);
	// A result takes a whole finish sequence, so a done pulse is never followed at once by another.
	`SRE_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// The queue only fills after a transfer in.
	`SRE_ASSERT(a_busy_after_start, clk, arst_n, !$rose(busy) || $past(start))
	// Configuration is always taken.
	`SRE_ASSERT(a_cfg_ready, clk, arst_n, cfg_ready)
endmodule

bind spline_refinement_error_norms sre_checker u_sre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_ready (cfg_ready),
	.done      (done)
);

[dv/tb.sv]
// Self-checking testbench for the spline refinement error norm block.
module tb;

	typedef struct {
		logic [1:0]         req_type;
		logic [10:0]        index;
		logic signed [31:0] val_x;
		logic signed [31:0] val_y;
		logic signed [31:0] val_z;
		logic [16:0]        weight;
		logic [30:0]        row_span;
		logic               last_in_row;
	} request_t;

	typedef struct {
		logic [30:0] max_err[3];
		logic [30:0] l2_err[3];
	} norms_t;

	localparam int KNOT_DEPTH = 1032;
	localparam int COEF_DEPTH = 1024;
	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam logic [63:0] OUT_MAX = 64'h7FFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = sre_pkg::REQ_KNOT;
	logic [10:0] index = '0;
	logic signed [31:0] val_x = '0;
	logic signed [31:0] val_y = '0;
	logic signed [31:0] val_z = '0;
	logic [16:0] weight = '0;
	logic [30:0] row_span = '0;
	logic last_in_row = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = sre_pkg::CFG_ORDER;
	logic [10:0] cfg_data = '0;
	logic done;
	logic [30:0] max_err_x, max_err_y, max_err_z;
	logic [30:0] l2_err_x, l2_err_y, l2_err_z;

	spline_refinement_error_norms u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .index(index), .val_x(val_x), .val_y(val_y),
		.val_z(val_z), .weight(weight), .row_span(row_span),
		.last_in_row(last_in_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.max_err_x(max_err_x), .max_err_y(max_err_y), .max_err_z(max_err_z),
		.l2_err_x(l2_err_x), .l2_err_y(l2_err_y), .l2_err_z(l2_err_z)
	);

	// Shadow of the block: registers, stores and accumulators.
	logic [3:0]  order_q = 4'd4;
	logic [1:0]  dim_q = 2'd3;
	logic [10:0] count_q = 11'd1024;
	logic [3:0]  left_q = '0;
	logic [3:0]  right_q = '0;
	longint      knot_mem [KNOT_DEPTH];
	bit          knot_ok [KNOT_DEPTH];
	longint      coef_mem [COEF_DEPTH][3];
	bit          coef_ok [COEF_DEPTH];
	longint      row_acc [3] = '{0, 0, 0};
	logic [63:0] max_acc [3] = '{0, 0, 0};
	logic [63:0] sumsq_acc [3] = '{0, 0, 0};

	norms_t pending_norms [$];
	int     fail_count = 0;
	int     burst_left = 0;
	int     loaded_cols [$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] res, b;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - res - b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic int order_eff();
		if (order_q == 0) return 1;
		if (order_q > 8) return 8;
		return int'(order_q);
	endfunction

	// Clamp a magnitude with sign to the 32-bit signed coefficient range.
	function automatic longint clamp_value(logic [63:0] mag, bit neg);
		if (neg) return (mag >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(mag);
		return (mag >= 64'h8000_0000) ? 64'sh7FFF_FFFF : longint'(mag);
	endfunction

	function automatic bit is_scaled(int i);
		return i >= int'(left_q) && i < int'(count_q) - int'(right_q);
	endfunction

	function automatic longint scale_coef(longint c, int i);
		int k;
		longint span;
		bit neg;
		logic [63:0] m, f;
		k = order_eff();
		span = knot_mem[i + k] - knot_mem[i];
		neg = c < 0;
		m = neg ? 64'(-c) : 64'(c);
		if (span <= 0) return (m == 0) ? 0 : clamp_value('1, neg);
		f = isqrt64((64'(k) << 48) / 64'(span));
		return clamp_value((m * f + 64'd32768) >> 16, neg);
	endfunction

	// Advance the shadow state by one accepted request; queue a result on finish.
	function automatic void apply_request(request_t r);
		longint v [3];
		int lanes, k, i;
		bit ok, neg;
		logic [63:0] m, p, d, t, s;
		logic [127:0] wide;
		longint a;
		norms_t n;
		v[0] = longint'(r.val_x);
		v[1] = longint'(r.val_y);
		v[2] = longint'(r.val_z);
		lanes = int'(dim_q);
		i = int'(r.index);
		ok = i < int'(count_q) && i < COEF_DEPTH;
		case (r.req_type)
			sre_pkg::REQ_KNOT: begin
				if (i < KNOT_DEPTH) begin
					knot_mem[i] = v[0];
					knot_ok[i] = 1'b1;
				end
			end
			sre_pkg::REQ_COEF: begin
				if (ok) begin
					for (int j = 0; j < 3; j++)
						coef_mem[i][j] = is_scaled(i) ? scale_coef(v[j], i) : v[j];
					coef_ok[i] = 1'b1;
				end
			end
			sre_pkg::REQ_ENTRY: begin
				for (int j = 0; j < lanes; j++) begin
					neg = ok && coef_mem[i][j] < 0;
					m = !ok ? 64'd0 : (neg ? 64'(-coef_mem[i][j]) : 64'(coef_mem[i][j]));
					p = (m * 64'(r.weight) + 64'd32768) >> 16;
					a = row_acc[j] + (neg ? -longint'(p) : longint'(p));
					row_acc[j] = a > ACC_MAX ? ACC_MAX : (a < ACC_MIN ? ACC_MIN : a);
				end
				if (r.last_in_row) begin
					k = order_eff();
					for (int j = 0; j < lanes; j++) begin
						a = row_acc[j] - v[j];
						d = a < 0 ? 64'(-a) : 64'(a);
						if (d > OUT_MAX) d = OUT_MAX;
						if (d > max_acc[j]) max_acc[j] = d;
						wide = (128'(d) * 128'(d) * 128'(r.row_span)) / (128'(k) << 16);
						t = (wide[127:64] != 0) ? '1 : wide[63:0];
						s = sumsq_acc[j] + t;
						sumsq_acc[j] = (s < t) ? '1 : s;
						row_acc[j] = 0;
					end
				end
			end
			default: begin
				for (int j = 0; j < 3; j++) begin
					m = 0;
					p = 0;
					if (j < lanes) begin
						m = max_acc[j];
						p = isqrt64(sumsq_acc[j]);
						if (p > OUT_MAX) p = OUT_MAX;
					end
					n.max_err[j] = m[30:0];
					n.l2_err[j] = p[30:0];
					row_acc[j] = 0;
					max_acc[j] = 0;
					sumsq_acc[j] = 0;
				end
				pending_norms.push_back(n);
			end
		endcase
	endfunction

	// Compare each finish result with the oldest expectation.
	task automatic check_field(string name, logic [30:0] exp_v, logic [30:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		norms_t n;
		if (arst_n && done) begin
			if (pending_norms.size() == 0) begin
				$error("result with no finish request outstanding");
				fail_count++;
			end else begin
				n = pending_norms.pop_front();
				check_field("max_err_x", n.max_err[0], max_err_x);
				check_field("max_err_y", n.max_err[1], max_err_y);
				check_field("max_err_z", n.max_err[2], max_err_z);
				check_field("l2_err_x", n.l2_err[0], l2_err_x);
				check_field("l2_err_y", n.l2_err[1], l2_err_y);
				check_field("l2_err_z", n.l2_err[2], l2_err_z);
			end
		end
	end

	// Transfer one request; hold start across a burst, drop it for a random gap.
	task automatic send(logic [1:0] rt, int idx, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] vz, int w, logic [30:0] span, bit last);
		request_t r;
		r.req_type = rt;
		r.index = 11'(idx);
		r.val_x = vx;
		r.val_y = vy;
		r.val_z = vz;
		r.weight = 17'(w);
		r.row_span = span;
		r.last_in_row = last;
		start <= 1'b1;
		req_type <= r.req_type;
		index <= r.index;
		val_x <= r.val_x;
		val_y <= r.val_y;
		val_z <= r.val_z;
		weight <= r.weight;
		row_span <= r.row_span;
		last_in_row <= r.last_in_row;
		do @(posedge clk); while (busy);
		apply_request(r);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Pause the sender until every expected result is in, then let the
	// back end finish any request that produces no result.
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (pending_norms.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] ri, int data);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= 11'(data);
		do @(posedge clk); while (!cfg_ready);
		case (ri)
			sre_pkg::CFG_ORDER: order_q = 4'(data);
			sre_pkg::CFG_DIM:   dim_q = 2'(data);
			sre_pkg::CFG_COUNT: count_q = 11'(data);
			sre_pkg::CFG_LEFT:  left_q = 4'(data);
			default:            right_q = 4'(data);
		endcase
	endtask

	task automatic set_config(int o, int d, int c, int l, int rr);
		cfg_write(sre_pkg::CFG_ORDER, o);
		cfg_write(sre_pkg::CFG_DIM, d);
		cfg_write(sre_pkg::CFG_COUNT, c);
		cfg_write(sre_pkg::CFG_LEFT, l);
		cfg_write(sre_pkg::CFG_RIGHT, rr);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
		endcase
	endfunction

	task automatic send_knot(int i);
		logic [31:0] kv;
		kv = ($urandom_range(0, 9) == 0) ? $urandom
			: 32'(i) * 32'h20000 + 32'($urandom_range(0, 32'h1FFFF));
		send(sre_pkg::REQ_KNOT, i, kv, $urandom, $urandom, $urandom_range(0, 131071),
			31'($urandom), $urandom_range(0, 1));
	endtask

	// Load a coefficient; scaling needs both knots of its span written first.
	task automatic load_coef(int i);
		int k;
		k = order_eff();
		if (i < int'(count_q) && i < COEF_DEPTH && is_scaled(i)) begin
			if (!knot_ok[i]) send_knot(i);
			if (!knot_ok[i + k]) send_knot(i + k);
		end
		send(sre_pkg::REQ_COEF, i, rand_q16(), rand_q16(), rand_q16(),
			$urandom_range(0, 131071), 31'($urandom), $urandom_range(0, 1));
		if (i < int'(count_q) && i < COEF_DEPTH) loaded_cols.push_back(i);
	endtask

	task automatic send_row(int entries);
		int col, w;
		logic [30:0] span;
		for (int e = 0; e < entries; e++) begin
			if ($urandom_range(0, 7) == 0 && count_q < 11'd2047)
				col = $urandom_range(int'(count_q), 2047);
			else
				col = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
				: $urandom_range(0, 65536);
			span = ($urandom_range(0, 9) == 0) ? 31'($urandom)
				: 31'($urandom_range(0, 32'h80000));
			send(sre_pkg::REQ_ENTRY, col, rand_q16(), rand_q16(), rand_q16(), w, span,
				e == entries - 1);
		end
	endtask

	// One configuration phase: coefficients, then rows with noise and finishes.
	task automatic run_phase(int budget);
		int lim, n_rows, k, sel, idx;
		loaded_cols.delete();
		lim = (int'(count_q) < COEF_DEPTH) ? int'(count_q) : COEF_DEPTH;
		k = order_eff();
		if (lim <= 16) begin
			for (int i = 0; i < lim; i++) load_coef(i);
		end else begin
			load_coef(0);
			load_coef(lim - 1);
			for (int i = 0; i < 12; i++) load_coef($urandom_range(0, lim - 1));
		end
		n_rows = 0;
		while (n_rows < budget) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) begin
				idx = $urandom_range(0, 2047);
				if ($urandom_range(0, 1)) begin
					send(sre_pkg::REQ_KNOT, idx, $urandom, $urandom, $urandom,
						$urandom_range(0, 131071), 31'($urandom), $urandom_range(0, 1));
				end else begin
					load_coef(idx);
				end
			end else if (sel == 1) begin
				send(sre_pkg::REQ_FINISH, $urandom_range(0, 2047), $urandom, $urandom,
					$urandom, $urandom_range(0, 131071), 31'($urandom),
					$urandom_range(0, 1));
			end else begin
				// Mostly well-formed rows of k entries, some short or long ones.
				send_row(($urandom_range(0, 4) == 0) ? $urandom_range(1, k + 1) : k);
			end
			n_rows += k;
		end
		send(sre_pkg::REQ_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
		drain();
	endtask

	// Reset defaults; extreme values, saturating scale, ignored indices.
	task automatic test_directed();
		send(sre_pkg::REQ_KNOT, 0, 32'h0, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_KNOT, 1, 32'h10000, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_KNOT, 2, 32'h20000, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_KNOT, 3, 32'h30000, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_KNOT, 4, 32'h40000, 0, 0, 0, 0, 1'b0);
		// Equal knots give a zero span for coefficient one.
		send(sre_pkg::REQ_KNOT, 5, 32'h10000, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_KNOT, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			131071, 31'h7FFF_FFFF, 1'b1);
		send(sre_pkg::REQ_COEF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0, 1'b0);
		send(sre_pkg::REQ_COEF, 1, 32'h50000, 32'hFFFD_0000, 32'h0, 0, 0, 1'b0);
		send(sre_pkg::REQ_COEF, 1500, 32'h1234_5678, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_ENTRY, 0, 0, 0, 0, 65536, 0, 1'b0);
		send(sre_pkg::REQ_ENTRY, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 131071,
			31'h7FFF_FFFF, 1'b1);
		send(sre_pkg::REQ_ENTRY, 1030, 32'h10000, 32'hFFFF_0000, 0, 0, 31'h10000, 1'b1);
		send(sre_pkg::REQ_ENTRY, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 65536,
			31'h7FFF_FFFF, 1'b1);
		send(sre_pkg::REQ_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
		send(sre_pkg::REQ_FINISH, 2047, 32'hFFFF_FFFF, 0, 0, 131071, 31'h7FFF_FFFF,
			1'b1);
		drain();
	endtask

	// Extreme settings: order clamping, no lanes, single coefficient, full store.
	task automatic test_config_extremes();
		set_config(0, 0, 1, 0, 0);
		run_phase(40);
		set_config(15, 1, 1, 8, 8);
		run_phase(60);
		set_config(8, 3, 1024, 8, 8);
		run_phase(120);
		set_config(1, 2, 2, 0, 0);
		run_phase(60);
		set_config(5, 3, 2047, 3, 2);
		run_phase(80);
	endtask

	task automatic test_random_settings();
		int c;
		for (int p = 0; p < 8; p++) begin
			c = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 24);
			set_config($urandom_range(0, 15),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3,
				c, $urandom_range(0, 15), $urandom_range(0, 15));
			run_phase(90);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_settings();
		if (fail_count == 0 && pending_norms.size() == 0) begin
			$display("[spline_refinement_error_norms] OK");
		end else begin
			if (pending_norms.size() != 0) $error("finish results never arrived");
			$display("[spline_refinement_error_norms] ERROR");
		end
		$finish;
	end

	// Watchdog: a stalled handshake ends the run.
	initial begin
		#6000000;
		$display("[spline_refinement_error_norms] ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/sre_pkg.sv
rtl/sre_div.sv
rtl/sre_sqrt.sv
rtl/sre_front.sv
rtl/sre_back.sv
rtl/spline_refinement_error_norms.sv
rtl/sre_checker.sv
dv/tb.sv
